>>> src/gmf_pkg.sv
// gmf_pkg: shared widths, register and mode codes, and the structs passed
// between the blocks of the grayscale morphology filter
// no dependencies
package gmf_pkg;

	localparam int PIX_W      = 8;
	localparam int COORD_W    = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	// filter modes
	localparam logic [1:0] MODE_ERODE  = 2'd0;
	localparam logic [1:0] MODE_DILATE = 2'd1;
	localparam logic [1:0] MODE_VGRAD  = 2'd2;
	localparam logic [1:0] MODE_HGRAD  = 2'd3;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KSIZE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd3;

	typedef logic [PIX_W-1:0] pix_t;

	// per-item bookkeeping carried alongside the pixel pipeline
	typedef struct packed {
		logic               emit;
		logic               last;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} gmf_meta_t;

	// minimum and maximum of one incoming window column
	typedef struct packed {
		pix_t lo;
		pix_t hi;
	} gmf_colsum_t;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		pix_t               value;
		logic               frame_done;
	} gmf_result_t;

endpackage

>>> src/grayscale_morphology_filter.sv
// grayscale_morphology_filter: top level, configuration registers, raster
// position counters and the pixel pipeline around line store and window
// depends on gmf_pkg, gmf_line, gmf_window, gmf_fifo
//
//  channel  handshake                     payload
//  pixel    pixel_valid / pixel_ready     pixel
//  result   result_valid / result_ready   out_row, out_col, value, frame_done
//  config   cfg_valid / cfg_ready         cfg_index, cfg_data
//
// one pixel per clock while pixel_ready is high; a result reaches the queue
// after its pixel passes line store read, column summary and window reduction
// the line store needs no clearing pass: only rows of the current frame are read
// pixel_ready drops once items in flight plus queued results reach the
// four-entry result queue; the pipeline itself never stalls
// cfg_ready is always high; a register write restarts the frame position
module grayscale_morphology_filter #(
	parameter int MAX_KERNEL = 8,
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [gmf_pkg::PIX_W-1:0]          pixel,
	input  logic                               pixel_valid,
	output logic                               pixel_ready,
	output logic [gmf_pkg::COORD_W-1:0]        out_row,
	output logic [gmf_pkg::COORD_W-1:0]        out_col,
	output logic [gmf_pkg::PIX_W-1:0]          value,
	output logic                               frame_done,
	output logic                               result_valid,
	input  logic                               result_ready,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [gmf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gmf_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int KW = $clog2(MAX_KERNEL + 1);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [1:0]   mode_q;
	logic [3:0]   ksize_q;
	logic [10:0]  width_q;
	logic [10:0]  height_q;
	logic [KW-1:0] k_eff;
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [KW-1:0] rows_used;
	logic [KW-1:0] cols_used;

	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic          col_last;
	logic          row_last;
	logic          row_fit;
	logic          col_fit;

	logic          pix_fire;
	logic          cfg_fire;
	logic          cfg_hit;

	gmf_pkg::gmf_meta_t   meta_in;
	gmf_pkg::gmf_meta_t   meta_s1;
	gmf_pkg::gmf_meta_t   meta_s2;
	logic                 v_s1;
	logic                 v_s2;
	gmf_pkg::gmf_colsum_t colsum;
	gmf_pkg::pix_t        win_value;
	gmf_pkg::gmf_result_t res_in;
	gmf_pkg::gmf_result_t res_head;
	logic [gmf_pkg::FIFO_AW:0] fifo_cnt;
	logic [gmf_pkg::FIFO_AW:0] busy;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_fire && (cfg_index == gmf_pkg::REG_MODE ||
		cfg_index == gmf_pkg::REG_KSIZE || cfg_index == gmf_pkg::REG_WIDTH ||
		cfg_index == gmf_pkg::REG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= gmf_pkg::MODE_ERODE;
			ksize_q  <= 4'd3;
			width_q  <= 11'd640;
			height_q <= 11'd480;
		end else if (cfg_fire) begin
			case (cfg_index)
				gmf_pkg::REG_MODE: begin
					mode_q <= cfg_data[1:0];
				end
				gmf_pkg::REG_KSIZE: begin
					ksize_q <= cfg_data[3:0];
				end
				gmf_pkg::REG_WIDTH: begin
					width_q <= cfg_data;
				end
				gmf_pkg::REG_HEIGHT: begin
					height_q <= cfg_data;
				end
				default: begin
					mode_q <= mode_q;
				end
			endcase
		end
	end

	// zero reads as one, oversize saturates
	always_comb begin
		if (ksize_q == '0) begin
			k_eff = KW'(1);
		end else if (32'(ksize_q) > MAX_KERNEL) begin
			k_eff = KW'(MAX_KERNEL);
		end else begin
			k_eff = KW'(ksize_q);
		end
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_q);
		end
	end

	assign rows_used = (mode_q == gmf_pkg::MODE_HGRAD) ? KW'(1) : k_eff;
	assign cols_used = (mode_q == gmf_pkg::MODE_VGRAD) ? KW'(1) : k_eff;

	assign col_last = (WW'(col_q) + WW'(1)) == w_eff;
	assign row_last = (HW'(row_q) + HW'(1)) == h_eff;
	assign row_fit  = (32'(row_q) + 32'd1) >= 32'(k_eff);
	assign col_fit  = (32'(col_q) + 32'd1) >= 32'(k_eff);

	always_comb begin
		case (mode_q)
			gmf_pkg::MODE_ERODE, gmf_pkg::MODE_DILATE: begin
				meta_in.emit = row_fit && col_fit;
			end
			gmf_pkg::MODE_VGRAD: begin
				meta_in.emit = row_fit;
			end
			default: begin
				meta_in.emit = col_fit;
			end
		endcase
		meta_in.last = row_last && col_last;
		meta_in.row  = gmf_pkg::COORD_W'(32'(row_q) + 32'd1 - 32'(rows_used));
		meta_in.col  = gmf_pkg::COORD_W'(32'(col_q) + 32'd1 - 32'(cols_used));
	end

	// every item in flight is counted against the result queue
	assign busy        = (gmf_pkg::FIFO_AW+1)'(v_s1) + (gmf_pkg::FIFO_AW+1)'(v_s2) + fifo_cnt;
	assign pixel_ready = busy < (gmf_pkg::FIFO_AW+1)'(gmf_pkg::FIFO_DEPTH);
	assign pix_fire    = pixel_valid && pixel_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_hit) begin
			row_q <= '0;
			col_q <= '0;
		end else if (pix_fire) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= pix_fire;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_fire) begin
			meta_s1 <= meta_in;
		end
		if (v_s1) begin
			meta_s2 <= meta_s1;
		end
	end

	gmf_line #(
		.MAX_KERNEL (MAX_KERNEL),
		.MAX_WIDTH  (MAX_WIDTH)
	) u_line (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (pix_fire),
		.rd_col    (col_q),
		.px        (pixel),
		.wr_en     (v_s1),
		.rows_used (rows_used),
		.colsum    (colsum)
	);

	gmf_window #(
		.MAX_KERNEL (MAX_KERNEL)
	) u_window (
		.clk       (clk),
		.shift_en  (v_s1),
		.colsum    (colsum),
		.cols_used (cols_used),
		.mode      (mode_q),
		.value     (win_value)
	);

	always_comb begin
		res_in.row        = meta_s2.row;
		res_in.col        = meta_s2.col;
		res_in.value      = win_value;
		res_in.frame_done = meta_s2.last;
	end

	gmf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s2 && meta_s2.emit),
		.push_data (res_in),
		.pop       (result_ready),
		.head      (res_head),
		.count     (fifo_cnt)
	);

	assign result_valid = fifo_cnt != '0;
	assign out_row      = res_head.row;
	assign out_col      = res_head.col;
	assign value        = res_head.value;
	assign frame_done   = res_head.frame_done;

endmodule

>>> src/gmf_line.sv
// gmf_line: column-organised line store (one word per image column holding
// the previous rows' pixels) with read-modify-write and same-column forwarding
// depends on gmf_pkg
module gmf_line #(
	parameter int MAX_KERNEL = 8,
	parameter int MAX_WIDTH  = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]         rd_col,
	input  gmf_pkg::pix_t                        px,
	input  logic                                 wr_en,
	input  logic [$clog2(MAX_KERNEL+1)-1:0]      rows_used,
	output gmf_pkg::gmf_colsum_t                 colsum
);

	localparam int LINES  = MAX_KERNEL - 1;
	localparam int WORD_W = LINES * gmf_pkg::PIX_W;
	localparam int NP     = 1 << $clog2(MAX_KERNEL);
	localparam int CW     = $clog2(MAX_WIDTH);

	logic [WORD_W-1:0] mem [MAX_WIDTH];
	logic [WORD_W-1:0] rd_word_q;
	logic [CW-1:0]     addr_s1;
	gmf_pkg::pix_t     px_s1;
	logic              fwd_s1;
	logic [WORD_W-1:0] fwd_word_s1;
	logic [WORD_W-1:0] old_word;
	logic [WORD_W-1:0] wr_word;
	logic [NP*gmf_pkg::PIX_W-1:0] col_all;
	gmf_pkg::pix_t     tmin [NP];
	gmf_pkg::pix_t     tmax [NP];

	// slot 0 of a word is the row just above, newest row shifts in at the bottom
	assign old_word = fwd_s1 ? fwd_word_s1 : rd_word_q;
	assign wr_word  = (old_word << gmf_pkg::PIX_W) | WORD_W'(px_s1);
	assign col_all  = (NP*gmf_pkg::PIX_W)'({old_word, px_s1});

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_s1] <= wr_word;
		end
		if (rd_en) begin
			rd_word_q   <= mem[rd_col];
			addr_s1     <= rd_col;
			px_s1       <= px;
			fwd_word_s1 <= wr_word;
		end
	end

	// a one-column image reads the entry being written back in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s1 <= 1'b0;
		end else begin
			fwd_s1 <= rd_en && wr_en && (rd_col == addr_s1);
		end
	end

	always_comb begin
		int s;
		for (int i = 0; i < NP; i++) begin
			if (i < int'(rows_used)) begin
				tmin[i] = col_all[i*gmf_pkg::PIX_W +: gmf_pkg::PIX_W];
				tmax[i] = col_all[i*gmf_pkg::PIX_W +: gmf_pkg::PIX_W];
			end else begin
				tmin[i] = '1;
				tmax[i] = '0;
			end
		end
		for (s = NP / 2; s > 0; s = s >> 1) begin
			for (int i = 0; i < s; i++) begin
				tmin[i] = (tmin[2*i+1] < tmin[2*i]) ? tmin[2*i+1] : tmin[2*i];
				tmax[i] = (tmax[2*i+1] > tmax[2*i]) ? tmax[2*i+1] : tmax[2*i];
			end
		end
		colsum.lo = tmin[0];
		colsum.hi = tmax[0];
	end

endmodule

>>> src/gmf_window.sv
// gmf_window: shift register of per-column min/max summaries and the
// reduction over the active columns into the filter value
// depends on gmf_pkg
module gmf_window #(
	parameter int MAX_KERNEL = 8
) (
	input  logic                             clk,
	input  logic                             shift_en,
	input  gmf_pkg::gmf_colsum_t             colsum,
	input  logic [$clog2(MAX_KERNEL+1)-1:0]  cols_used,
	input  logic [1:0]                       mode,
	output gmf_pkg::pix_t                    value
);

	localparam int NP = 1 << $clog2(MAX_KERNEL);

	gmf_pkg::pix_t cmin_q [MAX_KERNEL];
	gmf_pkg::pix_t cmax_q [MAX_KERNEL];
	gmf_pkg::pix_t tmin   [NP];
	gmf_pkg::pix_t tmax   [NP];
	gmf_pkg::pix_t win_lo;
	gmf_pkg::pix_t win_hi;

	// newest column at index 0
	always_ff @(posedge clk) begin
		if (shift_en) begin
			cmin_q[0] <= colsum.lo;
			cmax_q[0] <= colsum.hi;
			for (int j = 1; j < MAX_KERNEL; j++) begin
				cmin_q[j] <= cmin_q[j-1];
				cmax_q[j] <= cmax_q[j-1];
			end
		end
	end

	always_comb begin
		int s;
		for (int j = 0; j < NP; j++) begin
			if (j < MAX_KERNEL && j < int'(cols_used)) begin
				tmin[j] = cmin_q[j % MAX_KERNEL];
				tmax[j] = cmax_q[j % MAX_KERNEL];
			end else begin
				tmin[j] = '1;
				tmax[j] = '0;
			end
		end
		for (s = NP / 2; s > 0; s = s >> 1) begin
			for (int i = 0; i < s; i++) begin
				tmin[i] = (tmin[2*i+1] < tmin[2*i]) ? tmin[2*i+1] : tmin[2*i];
				tmax[i] = (tmax[2*i+1] > tmax[2*i]) ? tmax[2*i+1] : tmax[2*i];
			end
		end
		win_lo = tmin[0];
		win_hi = tmax[0];
	end

	always_comb begin
		case (mode)
			gmf_pkg::MODE_ERODE: begin
				value = win_lo;
			end
			gmf_pkg::MODE_DILATE: begin
				value = win_hi;
			end
			default: begin
				value = win_hi - win_lo;
			end
		endcase
	end

endmodule

>>> src/gmf_fifo.sv
// gmf_fifo: small result queue between the filter pipeline and the output port
// depends on gmf_pkg
module gmf_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  gmf_pkg::gmf_result_t          push_data,
	input  logic                          pop,
	output gmf_pkg::gmf_result_t          head,
	output logic [gmf_pkg::FIFO_AW:0]     count
);

	gmf_pkg::gmf_result_t           slot_q [gmf_pkg::FIFO_DEPTH];
	logic [gmf_pkg::FIFO_AW-1:0]    wr_ptr_q;
	logic [gmf_pkg::FIFO_AW-1:0]    rd_ptr_q;
	logic [gmf_pkg::FIFO_AW:0]      count_q;
	logic                           do_pop;

	assign do_pop = pop && (count_q != '0);
	assign head   = slot_q[rd_ptr_q];
	assign count  = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10: begin
					count_q <= count_q + 1'b1;
				end
				2'b01: begin
					count_q <= count_q - 1'b1;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule
